FILE: design/glpa_pkg.sv
`default_nettype none

package glpa_pkg;

  // Field widths fixed by the pixel stream format
  localparam int COL_W   = 7;
  localparam int PIX_W   = 8;
  localparam int ANGLE_W = 15;
  localparam int MAG_W   = 14;
  localparam int STAT_W  = 2;

  // Index compare width, wide enough for the largest frame side
  localparam int SIDE_W = 11;

  // Frame side and angle lookup geometry
  localparam int IMAGE_SIDE_DEF = 128;
  localparam int TAB_DEPTH      = 1 << COL_W;
  localparam int ANGLE_MAX      = 12868;
  localparam int CORDIC_STEPS   = 24;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_MULTI     = 2'd2
  } status_t;

  // Row scan view after the current item
  typedef struct packed {
    logic             near_found;
    logic             near_multi;
    logic [COL_W-1:0] near_col;
    logic             far_found;
    logic             far_multi;
    logic [COL_W-1:0] far_col;
  } scan_t;

  // atan(2^-i) in Q24 radians
  localparam longint ATAN_TAB [CORDIC_STEPS] = '{
    64'd13176795, 64'd7778716, 64'd4110060, 64'd2086331, 64'd1047214, 64'd524117,
    64'd262123, 64'd131069, 64'd65536, 64'd32768, 64'd16384, 64'd8192,
    64'd4096, 64'd2048, 64'd1024, 64'd512, 64'd256, 64'd128,
    64'd64, 64'd32, 64'd16, 64'd8, 64'd4, 64'd2
  };

  // Q14 magnitude of atan(mag / (side-1)), evaluated while building the table
  function automatic logic [MAG_W-1:0] angle_mag(input int mag, input int side);
    longint x;
    longint y;
    longint z;
    longint nx;
    longint ny;
    z = 0;
    x = longint'(side - 1) <<< 20;
    y = longint'(mag) <<< 20;
    if (mag == 0) begin
      return '0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - ATAN_TAB[i];
      end
      x = nx;
      y = ny;
    end
    if (z < 0) begin
      z = 0;
    end
    z = (z + 512) >>> 10;
    if (z > ANGLE_MAX) begin
      z = ANGLE_MAX;
    end
    return MAG_W'(z);
  endfunction

endpackage

`default_nettype wire

FILE: design/glpa_scan.sv
`default_nettype none

module glpa_scan
  import glpa_pkg::*;
#(
  parameter int IMAGE_SIDE = IMAGE_SIDE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [COL_W-1:0] row,
  input  wire logic [COL_W-1:0] col,
  input  wire logic             match,
  output scan_t                 view
);

  localparam logic [SIDE_W-1:0] LAST = SIDE_W'(IMAGE_SIDE - 1);
  localparam logic [SIDE_W-1:0] SIDE = SIDE_W'(IMAGE_SIDE);

  scan_t scan;
  scan_t scan_next;
  logic  prev_match;
  logic  prev_match_next;

  logic [SIDE_W-1:0] row_w;
  logic [SIDE_W-1:0] col_w;
  logic              col_ok;
  logic              is_near;
  logic              is_far;
  logic              first_col;
  logic              prev;

  assign row_w     = {{(SIDE_W-COL_W){1'b0}}, row};
  assign col_w     = {{(SIDE_W-COL_W){1'b0}}, col};
  assign col_ok    = col_w < SIDE;
  assign is_near   = col_ok && (row == '0);
  assign is_far    = col_ok && !is_near && (row_w == LAST);
  assign first_col = (col == '0);
  assign prev      = first_col ? 1'b0 : prev_match;

  // Update the watched row: clear at column 0, mark the first run, flag a second
  always_comb begin
    scan_next       = scan;
    prev_match_next = prev_match;
    if (is_near) begin
      if (first_col) begin
        scan_next.near_found = 1'b0;
        scan_next.near_multi = 1'b0;
      end
      if (match) begin
        if (!scan_next.near_found) begin
          scan_next.near_found = 1'b1;
          scan_next.near_col   = col;
        end else if (!prev) begin
          scan_next.near_multi = 1'b1;
        end
      end
      prev_match_next = match;
    end else if (is_far) begin
      if (first_col) begin
        scan_next.far_found = 1'b0;
        scan_next.far_multi = 1'b0;
      end
      if (match) begin
        if (!scan_next.far_found) begin
          scan_next.far_found = 1'b1;
          scan_next.far_col   = col;
        end else if (!prev) begin
          scan_next.far_multi = 1'b1;
        end
      end
      prev_match_next = match;
    end
  end

  assign view = scan_next;

  // Commit the scan state when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan       <= '0;
      prev_match <= 1'b0;
    end else if (step) begin
      scan       <= scan_next;
      prev_match <= prev_match_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/glpa_angle.sv
`default_nettype none

module glpa_angle
  import glpa_pkg::*;
#(
  parameter int IMAGE_SIDE = IMAGE_SIDE_DEF
) (
  input  wire logic [COL_W-1:0]          near_col,
  input  wire logic [COL_W-1:0]          far_col,
  output logic signed [ANGLE_W-1:0]      angle
);

  logic [MAG_W-1:0] tab [TAB_DEPTH];

  // Build the arctangent table for every column offset
  for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
    localparam logic [MAG_W-1:0] ENTRY = angle_mag(g, IMAGE_SIDE);
    assign tab[g] = ENTRY;
  end

  logic signed [COL_W:0] diff;
  logic        [COL_W:0] neg_diff;
  logic [COL_W-1:0]      mag;
  logic [ANGLE_W-1:0]    mag_ext;

  // Look up the magnitude, then apply the sign of near minus far
  assign diff     = $signed({1'b0, near_col}) - $signed({1'b0, far_col});
  assign neg_diff = -diff;
  assign mag      = diff[COL_W] ? neg_diff[COL_W-1:0] : diff[COL_W-1:0];
  assign mag_ext  = {{(ANGLE_W-MAG_W){1'b0}}, tab[mag]};
  assign angle    = diff[COL_W] ? $signed(-mag_ext) : $signed(mag_ext);

endmodule

`default_nettype wire

FILE: design/guideline_position_angle_core.sv
// Channel  | Direction | Handshake              | Payload
// pixel    | in        | pix_valid / pix_stall  | row, col, pixel
// result   | out       | res_valid / res_stall  | status, near_pos, far_pos, angle
// config   | in        | cfg_valid / cfg_ready  | cfg_data (guide_color)
//
// One pixel item per cycle while pix_stall stays low. A frame result becomes valid once the
// last far-row pixel has passed through the input register, then the result register.
// Scan update, status decision and arctangent lookup sit between the two registers.
// Reset (rst, synchronous) clears the scan state, the held angle and both valids;
// guide_color returns to 255. cfg_ready is always high.
// pix_stall rises only while a result waits and the input register holds the next one.
`default_nettype none

module guideline_position_angle_core
  import glpa_pkg::*;
#(
  parameter int IMAGE_SIDE = IMAGE_SIDE_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,

  input  wire logic                     pix_valid,
  output logic                          pix_stall,
  input  wire logic [COL_W-1:0]         row,
  input  wire logic [COL_W-1:0]         col,
  input  wire logic [PIX_W-1:0]         pixel,

  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [PIX_W-1:0]         cfg_data,

  output logic                          res_valid,
  input  wire logic                     res_stall,
  output logic [STAT_W-1:0]             status,
  output logic [COL_W-1:0]              near_pos,
  output logic [COL_W-1:0]              far_pos,
  output logic signed [ANGLE_W-1:0]     angle
);

  localparam logic [SIDE_W-1:0] LAST = SIDE_W'(IMAGE_SIDE - 1);

  logic [PIX_W-1:0] guide_color;

  logic             s1_valid;
  logic [COL_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic [PIX_W-1:0] s1_pixel;

  logic signed [ANGLE_W-1:0] held_angle;

  logic                      s1_emit;
  logic                      advance;
  logic                      take;
  scan_t                     view;
  logic signed [ANGLE_W-1:0] new_angle;
  status_t                   stat;

  // Guide color register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      guide_color <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      guide_color <= cfg_data;
    end
  end

  // Advance the input register unless its result cannot be stored
  assign s1_emit = ({{(SIDE_W-COL_W){1'b0}}, s1_row} == LAST) &&
                   ({{(SIDE_W-COL_W){1'b0}}, s1_col} == LAST);
  assign advance   = s1_valid && (!s1_emit || !res_valid || !res_stall);
  assign pix_stall = s1_valid && !advance;
  assign take      = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_row   <= row;
      s1_col   <= col;
      s1_pixel <= pixel;
    end
  end

  glpa_scan #(
    .IMAGE_SIDE(IMAGE_SIDE)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .row   (s1_row),
    .col   (s1_col),
    .match (s1_pixel == guide_color),
    .view  (view)
  );

  glpa_angle #(
    .IMAGE_SIDE(IMAGE_SIDE)
  ) u_angle (
    .near_col (view.near_col),
    .far_col  (view.far_col),
    .angle    (new_angle)
  );

  // Multiple runs win over a missing run
  always_comb begin
    priority if (view.near_multi || view.far_multi) begin
      stat = STAT_MULTI;
    end else if (!view.near_found || !view.far_found) begin
      stat = STAT_NOT_FOUND;
    end else begin
      stat = STAT_OK;
    end
  end

  // Result register and held angle
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      held_angle <= '0;
    end else if (advance && s1_emit) begin
      res_valid <= 1'b1;
      if (stat == STAT_OK) begin
        held_angle <= new_angle;
      end
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_emit) begin
      status <= stat;
      if (stat == STAT_OK) begin
        near_pos <= view.near_col;
        far_pos  <= view.far_col;
        angle    <= new_angle;
      end else begin
        near_pos <= '0;
        far_pos  <= '0;
        angle    <= held_angle;
      end
    end
  end

  // Stall only when the input register holds an item that cannot move
  assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (s1_valid && s1_emit && res_valid && res_stall))
    else $error("pixel stall without a blocked result");

  // Error results carry zero positions and the held angle
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != STAT_OK) |->
      (near_pos == '0 && far_pos == '0 && angle == held_angle))
    else $error("error result payload wrong");

  // An ok result is what the held angle now remembers
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == STAT_OK) |-> (angle == held_angle))
    else $error("held angle out of step with result");

  // Angle stays within plus or minus an eighth turn
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (angle <= ANGLE_W'(ANGLE_MAX) && angle >= -ANGLE_W'(ANGLE_MAX)))
    else $error("angle out of range");

endmodule

`default_nettype wire

FILE: dv/guideline_result_checker.sv
module guideline_result_checker
  import glpa_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     pix_valid,
  input  wire logic                     pix_stall,
  input  wire logic [COL_W-1:0]         row,
  input  wire logic [COL_W-1:0]         col,
  input  wire logic [PIX_W-1:0]         pixel,
  input  wire logic                     cfg_valid,
  input  wire logic                     cfg_ready,
  input  wire logic [PIX_W-1:0]         cfg_data,
  input  wire logic                     res_valid,
  input  wire logic                     res_stall,
  input  wire logic [STAT_W-1:0]        status,
  input  wire logic [COL_W-1:0]         near_pos,
  input  wire logic [COL_W-1:0]         far_pos,
  input  wire logic signed [ANGLE_W-1:0] angle,
  output int                            mismatches,
  output int                            reports_waiting
);

  localparam int LAST = IMAGE_SIDE_DEF - 1;
  localparam int NEAR = 0;
  localparam int FAR  = 1;

  // atan(2^-k) in Q24 radians
  localparam longint ARC_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct packed {
    status_t                     code;
    logic [COL_W-1:0]            near;
    logic [COL_W-1:0]            far;
    logic signed [ANGLE_W-1:0]   slope;
  } line_report_t;

  logic [PIX_W-1:0]          line_color;
  logic                      found [2];
  logic                      multi [2];
  logic [COL_W-1:0]          first_col [2];
  logic                      prev_hit;
  logic signed [ANGLE_W-1:0] last_slope;
  line_report_t              line_reports [$];
  int                        bad;

  // Q14 angle of atan(diff / (side-1)) by vectoring rotations
  function automatic logic signed [ANGLE_W-1:0] slope_angle(input int diff);
    longint xv;
    longint yv;
    longint acc;
    longint xn;
    longint dir;
    int mag;
    logic signed [ANGLE_W-1:0] q;
    mag = (diff < 0) ? -diff : diff;
    if (mag == 0) begin
      return '0;
    end
    xv  = longint'(LAST) <<< 20;
    yv  = longint'(mag) <<< 20;
    acc = 0;
    for (int k = 0; k < 24; k++) begin
      dir = (yv >= 0) ? 1 : -1;
      xn  = xv + dir * (yv >>> k);
      yv  = yv - dir * (xv >>> k);
      xv  = xn;
      acc = acc + dir * ARC_Q24[k];
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 512) >>> 10;
    if (acc > ANGLE_MAX) begin
      acc = ANGLE_MAX;
    end
    q = acc[ANGLE_W-1:0];
    return (diff < 0) ? -q : q;
  endfunction

  // Update the row scan for one pixel and queue a report at the frame end
  task automatic track_pixel(input logic [COL_W-1:0] r, input logic [COL_W-1:0] c,
                             input logic [PIX_W-1:0] p);
    logic hit;
    logic left;
    int w;
    line_report_t rep;
    hit = (p == line_color);
    if (r == 0) begin
      w = NEAR;
    end else if (r == COL_W'(LAST)) begin
      w = FAR;
    end else begin
      w = -1;
    end
    if (w >= 0) begin
      left = (c == 0) ? 1'b0 : prev_hit;
      if (c == 0) begin
        found[w] = 1'b0;
        multi[w] = 1'b0;
      end
      if (hit) begin
        if (!found[w]) begin
          found[w]     = 1'b1;
          first_col[w] = c;
        end else if (!left) begin
          multi[w] = 1'b1;
        end
      end
      prev_hit = hit;
    end
    if (r == COL_W'(LAST) && c == COL_W'(LAST)) begin
      rep.near = '0;
      rep.far  = '0;
      if (multi[NEAR] || multi[FAR]) begin
        rep.code = STAT_MULTI;
      end else if (!found[NEAR] || !found[FAR]) begin
        rep.code = STAT_NOT_FOUND;
      end else begin
        rep.code   = STAT_OK;
        rep.near   = first_col[NEAR];
        rep.far    = first_col[FAR];
        last_slope = slope_angle(int'(first_col[NEAR]) - int'(first_col[FAR]));
      end
      rep.slope = last_slope;
      line_reports.push_back(rep);
    end
  endtask

  // Compare one accepted result with the oldest queued report
  task automatic check_report();
    line_report_t want;
    if (line_reports.size() == 0) begin
      bad++;
      if (bad <= 10) begin
        $display("unexpected result: status %0d near %0d far %0d angle %0d",
                 status, near_pos, far_pos, angle);
      end
    end else begin
      want = line_reports.pop_front();
      if (status !== want.code || near_pos !== want.near || far_pos !== want.far ||
          angle !== want.slope) begin
        bad++;
        if (bad <= 10) begin
          $display("result mismatch: status %0d/%0d near %0d/%0d far %0d/%0d angle %0d/%0d",
                   want.code, status, want.near, near_pos, want.far, far_pos,
                   want.slope, angle);
        end
      end
    end
  endtask

  // Watch the channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      line_color = 8'hFF;
      for (int k = 0; k < 2; k++) begin
        found[k]     = 1'b0;
        multi[k]     = 1'b0;
        first_col[k] = '0;
      end
      prev_hit   = 1'b0;
      last_slope = '0;
      line_reports.delete();
      bad = 0;
    end else begin
      if (res_valid && !res_stall) begin
        check_report();
      end
      if (pix_valid && !pix_stall) begin
        track_pixel(row, col, pixel);
      end
      if (cfg_valid && cfg_ready) begin
        line_color = cfg_data;
      end
    end
    mismatches      <= bad;
    reports_waiting <= line_reports.size();
  end

endmodule

FILE: dv/tb.sv
module tb;
  import glpa_pkg::*;

  localparam int LAST        = IMAGE_SIDE_DEF - 1;
  localparam int STOP_CYCLES = 300000;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      pix_valid = 1'b0;
  logic                      pix_stall;
  logic [COL_W-1:0]          row       = '0;
  logic [COL_W-1:0]          col       = '0;
  logic [PIX_W-1:0]          pixel     = '0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [PIX_W-1:0]          cfg_data  = '0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic [STAT_W-1:0]         status;
  logic [COL_W-1:0]          near_pos;
  logic [COL_W-1:0]          far_pos;
  logic signed [ANGLE_W-1:0] angle;

  int mismatches;
  int reports_waiting;
  int snd_idle      = 32;
  int rcv_idle      = 72;
  bit hold_go       = 1'b0;
  bit hold_used     = 1'b0;
  int hold_left     = 0;
  int cycles        = 0;
  int items_sent    = 0;
  int frames_closed = 0;
  logic [PIX_W-1:0] line_color = 8'hFF;

  guideline_position_angle_core #(
    .IMAGE_SIDE(IMAGE_SIDE_DEF)
  ) u_dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall),
    .row(row), .col(col), .pixel(pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .near_pos(near_pos), .far_pos(far_pos), .angle(angle)
  );

  guideline_result_checker u_check (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall),
    .row(row), .col(col), .pixel(pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .near_pos(near_pos), .far_pos(far_pos), .angle(angle),
    .mismatches(mismatches), .reports_waiting(reports_waiting)
  );

  always #5 clk = ~clk;

  // Stop a runaway simulation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= STOP_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Drive result stall: one long hold when asked, random stalls otherwise
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      res_stall <= 1'b1;
      hold_left <= 400;
      hold_used <= 1'b1;
    end else begin
      res_stall <= (rcv_idle != 0) && ($urandom_range(99) < rcv_idle);
    end
  end

  // Pick a pixel value that does not match the guideline color
  function automatic logic [PIX_W-1:0] off_color();
    logic [PIX_W-1:0] p;
    p = PIX_W'($urandom_range(255));
    if (p == line_color) begin
      p = p + 8'd1;
    end
    return p;
  endfunction

  // Offer one pixel item and hold it until accepted
  task automatic send_pix(input int r, input int c, input logic [PIX_W-1:0] p);
    while (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    row       <= COL_W'(r);
    col       <= COL_W'(c);
    pixel     <= p;
    @(posedge clk);
    while (pix_stall) begin
      @(posedge clk);
    end
    items_sent++;
    if (r == LAST && c == LAST) begin
      frames_closed++;
    end
  endtask

  // Wait until every queued report has come out and the pipeline is empty
  task automatic settle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (reports_waiting != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  // Write the guideline color register
  task automatic set_color(input logic [PIX_W-1:0] c);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    line_color = c;
  endtask

  // Send one watched row: usually column 0, a window of columns, and column 127 when closing
  task automatic scan_row(input int r, input bit closing);
    logic [LAST:0] hit;
    int a;
    int b;
    int s;
    int e;
    int t;
    int kind;
    hit = '0;
    a = $urandom_range(1, LAST);
    b = a + $urandom_range(0, 23);
    if (b > LAST) begin
      b = LAST;
    end
    if ($urandom_range(99) < 3) begin
      a = 1;
      b = LAST;
    end
    kind = $urandom_range(9);
    if (kind >= 2) begin
      s = $urandom_range(a, b);
      e = $urandom_range(s, b);
      for (int k = s; k <= e; k++) hit[k] = 1'b1;
      // add a second run past a gap
      if (kind >= 8 && e + 2 <= b) begin
        s = $urandom_range(e + 2, b);
        t = $urandom_range(s, b);
        for (int k = s; k <= t; k++) hit[k] = 1'b1;
      end
    end
    if ($urandom_range(9) == 0) hit[0] = 1'b1;
    if ($urandom_range(9) == 0) hit[LAST] = 1'b1;
    // occasionally drop column 0 so the old flags carry over
    if ($urandom_range(99) >= 6) begin
      send_pix(r, 0, hit[0] ? line_color : off_color());
    end
    for (int k = a; k <= b; k++) begin
      send_pix(r, k, hit[k] ? line_color : off_color());
    end
    if (closing && b != LAST) begin
      send_pix(r, LAST, hit[LAST] ? line_color : off_color());
    end
  endtask

  // One frame: usually a near row, some pixels of other rows, far row, and rare stray items
  task automatic one_frame();
    int n;
    if ($urandom_range(99) < 90) begin
      scan_row(0, 1'b0);
    end
    n = $urandom_range(0, 3);
    repeat (n) send_pix($urandom_range(1, LAST - 1), $urandom_range(LAST),
                        PIX_W'($urandom_range(255)));
    scan_row(LAST, $urandom_range(99) < 95);
    if ($urandom_range(99) < 5) begin
      send_pix($urandom_range(LAST), $urandom_range(LAST), PIX_W'($urandom_range(255)));
    end
  endtask

  // Random frames under one color and one idling pattern
  task automatic run_phase(input int s_idle, input int r_idle, input logic [PIX_W-1:0] c,
                           input bit squeeze);
    int item0;
    int frame0;
    set_color(c);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    hold_go  = squeeze;
    item0    = items_sent;
    frame0   = frames_closed;
    while (items_sent - item0 < 600 || frames_closed - frame0 < 16) begin
      one_frame();
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // guideline at far left of near row, far right of far row
    send_pix(0, 0, 8'hFF);
    send_pix(LAST, 0, 8'h00);
    send_pix(LAST, LAST, 8'hFF);
    // mirror image of the above
    send_pix(0, 0, 8'hFE);
    send_pix(0, LAST, 8'hFF);
    send_pix(LAST, 0, 8'hFF);
    send_pix(LAST, LAST, 8'h7F);
    // far row end without column 0: flags of the last frame stay
    send_pix(LAST, LAST, 8'h00);
    // nothing found, angle held
    send_pix(0, 0, 8'h01);
    send_pix(LAST, 0, 8'h80);
    send_pix(LAST, LAST, 8'hFE);
    // equal columns, other row in between
    send_pix(0, 0, 8'h00);
    send_pix(0, 5, 8'hFF);
    send_pix(64, 3, 8'hFF);
    send_pix(LAST, 0, 8'h00);
    send_pix(LAST, 5, 8'hFF);
    send_pix(LAST, LAST, 8'h00);
    // second run in near row while far row has none
    send_pix(0, 0, 8'hFF);
    send_pix(0, 1, 8'h00);
    send_pix(0, 2, 8'hFF);
    send_pix(LAST, 0, 8'h00);
    send_pix(LAST, LAST, 8'h00);
    settle();

    run_phase(32, 72, 8'h00, 1'b0);
    run_phase(72, 32, PIX_W'($urandom_range(1, 254)), 1'b0);
    run_phase(0, 0, 8'hFF, 1'b1);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/glpa_pkg.sv
design/glpa_scan.sv
design/glpa_angle.sv
design/guideline_position_angle_core.sv
dv/guideline_result_checker.sv
dv/tb.sv
